>>> rtl/core/msst_pkg.sv
// package for the maximum-subarray segment tree unit
// shared constants, node and memory entry types, signed max helper
// no dependencies
`timescale 1ns / 1ps

package msst_pkg;

  localparam int LEAVES  = 4096;
  localparam int LEVELS  = $clog2(LEAVES);
  localparam int NODE_W  = LEVELS + 1;
  localparam int NODES   = 2 * LEAVES;
  localparam int POS_W   = 12;
  localparam int DELTA_W = 32;
  localparam int SUM_W   = 64;
  localparam int EPOCH_W = 8;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 128;

  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    sum_t prefix;
    sum_t suffix;
    sum_t run;
    sum_t total;
  } node_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    node_t              node;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic sum_t smax(sum_t x, sum_t y);
    return ($signed(x) >= $signed(y)) ? x : y;
  endfunction

endpackage

>>> rtl/core/msst_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module msst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/msst_merge.sv
// shared node merge unit: combines a left and a right child into their parent
// registers pre1..tot1, then pre2..tot2; the parent.run max is combinational
// depends on msst_pkg
`timescale 1ns / 1ps

module msst_merge
  import msst_pkg::*;
(
  input  logic  clk,
  input  node_t left,
  input  node_t right,
  output node_t parent
);

  sum_t pre1, suf1, m1, ssp1, tot1;
  sum_t pre2, suf2, m2, m3, tot2;

  always_ff @(posedge clk) begin
    pre1 <= smax(left.prefix, left.total + right.prefix);
    suf1 <= smax(right.suffix, left.suffix + right.total);
    m1   <= smax(left.run, right.run);
    ssp1 <= left.suffix + right.prefix;
    tot1 <= left.total + right.total;
  end

  always_ff @(posedge clk) begin
    pre2 <= pre1;
    suf2 <= suf1;
    m2   <= smax(pre1, suf1);
    m3   <= smax(m1, ssp1);
    tot2 <= tot1;
  end

  always_comb begin
    parent.prefix = pre2;
    parent.suffix = suf2;
    parent.run    = smax(m2, m3);
    parent.total  = tot2;
  end

endmodule

>>> rtl/core/max_subarray_segment_tree_unit.sv
// top level of the maximum-subarray segment tree unit
// depends on msst_pkg, msst_ram, msst_merge
//
// Keeps LEAVES signed 64-bit entries as a segment tree in one ram and reports
// the largest nonempty run sum and the total after every transaction. An add
// reads its leaf, updates it in S_LEAF, then goes through S_CAP, S_M2 and S_M3
// for each tree level: the shared merge unit is fed by one sibling read per
// level from the single ram read port. A clear bumps an epoch tag, so entries
// with an older tag read as zero; every 256th clear, and the time after reset,
// adds a sweep over all 2 * LEAVES ram entries (8192) that zeroes the ram,
// during which s_tready is low. A finished result waits in the output register
// while the next transaction is taken.
`timescale 1ns / 1ps

module max_subarray_segment_tree_unit
  import msst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // position[11:0], delta[43:12], zero pad
  input  logic                 s_tuser,   // operation
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // best_sum[63:0], total_sum[127:64]
);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LEAF  = 3'd2;
  localparam logic [2:0] S_CAP   = 3'd3;
  localparam logic [2:0] S_M2    = 3'd4;
  localparam logic [2:0] S_M3    = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  logic [2:0]         state;
  logic [NODE_W-1:0]  node;
  logic [NODE_W-1:0]  sweep_addr;
  logic [EPOCH_W-1:0] epoch;
  logic               sweep_pend;
  logic [DELTA_W-1:0] delta;
  node_t              cur;
  sum_t               best_out;
  sum_t               total_out;

  logic [POS_W-1:0]   pos_in;
  logic [DELTA_W-1:0] delta_in;
  logic               op_in;
  logic               in_range;
  logic [NODE_W-1:0]  leaf_in;
  logic [NODE_W-1:0]  node_up;
  sum_t               delta_ext;

  logic               we;
  logic [NODE_W-1:0]  waddr;
  logic [NODE_W-1:0]  raddr;
  entry_t             wentry;
  logic [ENTRY_W-1:0] rdata;
  entry_t             rentry;
  node_t              rd_node;
  node_t              left;
  node_t              right;
  node_t              parent;
  logic               out_load;

  assign pos_in    = s_tdata[POS_W-1:0];
  assign delta_in  = s_tdata[POS_W +: DELTA_W];
  assign op_in     = s_tuser;
  assign in_range  = int'(pos_in) < LEAVES;
  assign leaf_in   = NODE_W'(LEAVES) | NODE_W'(pos_in);
  assign node_up   = {1'b0, node[NODE_W-1:1]};
  assign delta_ext = {{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta};

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);
  assign m_tdata  = {total_out, best_out};

  // ram access
  assign rentry  = entry_t'(rdata);
  assign rd_node = (rentry.tag == epoch) ? rentry.node : '0;

  always_comb begin
    we         = (state == S_CAP) || (state == S_SWEEP);
    waddr      = (state == S_SWEEP) ? sweep_addr : node;
    wentry.tag = epoch;
    wentry.node = (state == S_SWEEP) ? '0 : cur;
    case (state)
      S_IDLE:  raddr = leaf_in;
      S_M3:    raddr = node_up ^ NODE_W'(1);
      default: raddr = node ^ NODE_W'(1);
    endcase
  end

  msst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rdata)
  );

  // current node is the left child when its index is even
  assign left  = node[0] ? rd_node : cur;
  assign right = node[0] ? cur : rd_node;

  msst_merge u_merge (
    .clk    (clk),
    .left   (left),
    .right  (right),
    .parent (parent)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_addr <= '0;
      epoch      <= '0;
      sweep_pend <= 1'b0;
      cur        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + NODE_W'(1);
          if (sweep_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            if (op_in == OP_CLEAR) begin
              cur <= '0;
              if (epoch == '1) begin
                sweep_pend <= 1'b1;
              end
              epoch <= epoch + EPOCH_W'(1);
              state <= S_DONE;
            end else if (in_range) begin
              node  <= leaf_in;
              delta <= delta_in;
              state <= S_LEAF;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_LEAF: begin
          cur.prefix <= rd_node.prefix + delta_ext;
          cur.suffix <= rd_node.suffix + delta_ext;
          cur.run    <= rd_node.run + delta_ext;
          cur.total  <= rd_node.total + delta_ext;
          state      <= S_CAP;
        end
        S_CAP: begin
          state <= S_M2;
        end
        S_M2: begin
          state <= S_M3;
        end
        S_M3: begin
          cur  <= parent;
          node <= node_up;
          if (node_up == NODE_W'(1)) begin
            state <= S_DONE;
          end else begin
            state <= S_CAP;
          end
        end
        S_DONE: begin
          if (out_load) begin
            sweep_pend <= 1'b0;
            state      <= sweep_pend ? S_SWEEP : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      best_out  <= cur.run;
      total_out <= cur.total;
    end
  end

  // unused pad bits of the input transaction
  logic unused_pad;
  assign unused_pad = ^s_tdata[S_TDATA_W-1:POS_W+DELTA_W] & (op_in == OP_ADD);

endmodule

>>> bench/tb_max_subarray_segment_tree_unit.sv
// testbench for max_subarray_segment_tree_unit: directed table, then random adds and clears
// keeps its own segment tree of the array and checks every result against it, or against the sums pinned in the table
// depends on msst_pkg and the unit under test
`timescale 1ns / 1ps

module tb_max_subarray_segment_tree_unit;
  import msst_pkg::*;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef struct {
    op_e              op;
    logic [POS_W-1:0] pos;
    logic [31:0]      delta;
    bit               pinned;
    sum_t             best;
    sum_t             total;
  } stim_row_t;

  typedef struct {
    bit   pinned;
    sum_t best;
    sum_t total;
  } pin_t;

  typedef struct {
    sum_t best;
    sum_t total;
  } root_sums_t;

  localparam int ROWS        = 17;
  localparam int RAND_ITEMS  = 700;
  localparam int DRAIN_WAIT  = 120;
  localparam int PRINT_LIMIT = 40;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;  // position[11:0], delta[43:12], zero pad
  logic                 s_tuser  = OP_ADD;  // operation
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;  // best_sum[63:0], total_sum[127:64]

  sum_t prefix_best [NODES];
  sum_t suffix_best [NODES];
  sum_t run_best    [NODES];
  sum_t span_total  [NODES];

  pin_t       pinned_q[$];
  root_sums_t root_sums_q[$];
  int         errors = 0;
  bit         calm   = 1'b0;

  stim_row_t rows [ROWS] = '{
    '{OP_ADD,   12'd0,    32'h0000_0000, 1'b1, 64'd0, 64'd0},
    '{OP_ADD,   12'd4095, 32'h7FFF_FFFF, 1'b1, 64'd2147483647, 64'd2147483647},
    '{OP_ADD,   12'd0,    32'h8000_0000, 1'b1, 64'd2147483647, 64'hFFFF_FFFF_FFFF_FFFF},
    '{OP_CLEAR, 12'hFFF,  32'hFFFF_FFFF, 1'b1, 64'd0, 64'd0},
    '{OP_ADD,   12'd0,    32'h8000_0000, 1'b1, 64'd0, 64'hFFFF_FFFF_8000_0000},
    '{OP_ADD,   12'd2048, 32'hFFFF_FFFB, 1'b0, 64'd0, 64'd0},
    '{OP_ADD,   12'd2047, 32'h0000_000A, 1'b0, 64'd0, 64'd0},
    '{OP_ADD,   12'd1,    32'hFFFF_FFFF, 1'b0, 64'd0, 64'd0},
    '{OP_ADD,   12'd4094, 32'h7FFF_FFFF, 1'b0, 64'd0, 64'd0},
    '{OP_ADD,   12'd4095, 32'h7FFF_FFFF, 1'b0, 64'd0, 64'd0},
    '{OP_ADD,   12'd4095, 32'h8000_0000, 1'b0, 64'd0, 64'd0},
    '{OP_ADD,   12'hAAA,  32'h5555_5555, 1'b0, 64'd0, 64'd0},
    '{OP_ADD,   12'h555,  32'hAAAA_AAAA, 1'b0, 64'd0, 64'd0},
    '{OP_CLEAR, 12'd0,    32'h0000_0000, 1'b1, 64'd0, 64'd0},
    '{OP_ADD,   12'hFFF,  32'h8000_0000, 1'b1, 64'd0, 64'hFFFF_FFFF_8000_0000},
    '{OP_ADD,   12'd0,    32'h8000_0000, 1'b1, 64'd0, 64'hFFFF_FFFF_0000_0000},
    '{OP_ADD,   12'd100,  32'h0000_0003, 1'b0, 64'd0, 64'd0}
  };

  max_subarray_segment_tree_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic sum_t larger(sum_t a, sum_t b);
    if ($signed(a) >= $signed(b)) return a;
    return b;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // --- segment tree of the array ---

  task automatic wipe_tree();
    for (int k = 0; k < NODES; k++) begin
      prefix_best[k] = '0;
      suffix_best[k] = '0;
      run_best[k]    = '0;
      span_total[k]  = '0;
    end
  endtask

  task automatic remerge(int k);
    int   a;
    int   b;
    sum_t pre;
    sum_t suf;
    sum_t run;
    a   = 2 * k;
    b   = 2 * k + 1;
    pre = larger(prefix_best[a], span_total[a] + prefix_best[b]);
    suf = larger(suffix_best[b], suffix_best[a] + span_total[b]);
    run = larger(pre, suf);
    run = larger(run, run_best[a]);
    run = larger(run, run_best[b]);
    run = larger(run, suffix_best[a] + prefix_best[b]);
    prefix_best[k] = pre;
    suffix_best[k] = suf;
    run_best[k]    = run;
    span_total[k]  = span_total[a] + span_total[b];
  endtask

  task automatic tree_apply(op_e op, logic [POS_W-1:0] pos, logic [31:0] delta);
    int   k;
    sum_t d;
    if (op == OP_CLEAR) begin
      wipe_tree();
    end else begin
      d = {{(SUM_W-32){delta[31]}}, delta};
      k = LEAVES + int'(pos);
      prefix_best[k] += d;
      suffix_best[k] += d;
      run_best[k]    += d;
      span_total[k]  += d;
      k = k / 2;
      while (k >= 1) begin
        remerge(k);
        k = k / 2;
      end
    end
  endtask

  // --- predict on input transaction, compare on output transaction ---

  always @(posedge clk) begin
    pin_t       pin;
    root_sums_t exp_sums;
    sum_t       got_best;
    sum_t       got_total;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pin = pinned_q.pop_front();
        tree_apply(op_e'(s_tuser), s_tdata[POS_W-1:0], s_tdata[POS_W+DELTA_W-1:POS_W]);
        if (pin.pinned) root_sums_q.push_back('{pin.best, pin.total});
        else root_sums_q.push_back('{run_best[1], span_total[1]});
      end
      if (m_tvalid && m_tready) begin
        got_best  = m_tdata[SUM_W-1:0];
        got_total = m_tdata[2*SUM_W-1:SUM_W];
        if (root_sums_q.size() == 0) begin
          errors++;
          if (errors <= PRINT_LIMIT)
            $display("%0t: unexpected result best %0d total %0d", $time,
                     $signed(got_best), $signed(got_total));
        end else begin
          exp_sums = root_sums_q.pop_front();
          if (got_best !== exp_sums.best) begin
            errors++;
            if (errors <= PRINT_LIMIT)
              $display("%0t: best_sum expected %0d actual %0d", $time,
                       $signed(exp_sums.best), $signed(got_best));
          end
          if (got_total !== exp_sums.total) begin
            errors++;
            if (errors <= PRINT_LIMIT)
              $display("%0t: total_sum expected %0d actual %0d", $time,
                       $signed(exp_sums.total), $signed(got_total));
          end
        end
      end
    end
  end

  // --- result side ---

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
        hold = idle_len();
      end
    end
  end

  // --- input side ---

  task automatic send(op_e op, logic [POS_W-1:0] pos, logic [31:0] delta,
                      bit pinned, sum_t best, sum_t total);
    int gap;
    pinned_q.push_back('{pinned, best, total});
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(S_TDATA_W-POS_W-DELTA_W){1'b0}}, delta, pos};
    do @(posedge clk); while (!s_tready);
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 32'($signed($urandom_range(0, 200)) - 100);
    if (r < 50) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int               clear_pct;
    int               r;
    logic [POS_W-1:0] window;
    logic [POS_W-1:0] pos;
    op_e              op;
    wipe_tree();
    window = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < ROWS; i++)
      send(rows[i].op, rows[i].pos, rows[i].delta, rows[i].pinned,
           rows[i].best, rows[i].total);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      calm = (i >= 100 && i < 200);
      // clear-heavy stretch to run through the epoch wrap of the unit
      clear_pct = (i >= 300 && i < 600) ? 80 : 5;
      if (i == 350 || i == 650) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (root_sums_q.size() != 0 || pinned_q.size() != 0) @(posedge clk);
      end
      if (i % 40 == 0) window = POS_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 50) pos = window + POS_W'($urandom_range(0, 15));
      else if (r < 60) pos = $urandom_range(0, 1) ? '1 : '0;
      else pos = POS_W'($urandom);
      op = ($urandom_range(0, 99) < clear_pct) ? OP_CLEAR : OP_ADD;
      send(op, pos, pick_delta(), 1'b0, '0, '0);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (root_sums_q.size() != 0 || pinned_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0 && root_sums_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
